>>> rtl/core/fsksf_pkg.sv
// Package for the FSK symbol framer: request kinds, register indexes,
// field widths and frame constants. Depends on nothing.
package fsksf_pkg;

  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  // Number of alternating preamble symbols; the first one is the one-tone.
  localparam logic [7:0] PREAMBLE_SYMBOLS = 8'd8;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_START = 2'd1;
  localparam kind_t KIND_STOP  = 2'd2;
  localparam kind_t KIND_LOAD  = 2'd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ZERO_TONE   = 3'd0;
  localparam reg_idx_t REG_ONE_TONE    = 3'd1;
  localparam reg_idx_t REG_SYMBOL_TICK = 3'd2;
  localparam reg_idx_t REG_PAYLOAD_LEN = 3'd3;
  localparam reg_idx_t REG_REPEAT      = 3'd4;
  localparam reg_idx_t REG_CHECK       = 3'd5;

  localparam logic [15:0] SYMBOL_TICKS_RESET = 16'd100;

endpackage

>>> rtl/core/fsksf_if.sv
// Request and result channel interfaces of the FSK symbol framer.
// Depends on fsksf_pkg for the field widths and the kind type.
interface fsksf_in_if;
  logic                                valid;
  logic                                ready;
  fsksf_pkg::kind_t                    kind;
  logic [fsksf_pkg::IDX_W-1:0]         load_index;
  logic [fsksf_pkg::BYTE_W-1:0]        load_byte;

  modport source (output valid, output kind, output load_index, output load_byte,
                  input ready);
  modport sink (input valid, input kind, input load_index, input load_byte,
                output ready);
endinterface

interface fsksf_out_if;
  logic                                valid;
  logic                                ready;
  logic                                tone_on;
  logic [fsksf_pkg::FREQ_W-1:0]        tone_freq;
  logic                                tone_changed;
  logic                                busy_res;
  logic                                start_rejected;
  logic [fsksf_pkg::COUNT_W-1:0]       symbol_total;
  logic [fsksf_pkg::COUNT_W-1:0]       byte_total;

  modport source (output valid, output tone_on, output tone_freq, output tone_changed,
                  output busy_res, output start_rejected, output symbol_total,
                  output byte_total, input ready);
  modport sink (input valid, input tone_on, input tone_freq, input tone_changed,
                input busy_res, input start_rejected, input symbol_total,
                input byte_total, output ready);
endinterface

>>> rtl/core/fsk_symbol_framer_core.sv
// Top level of the FSK symbol framer: request register, framing state,
// payload store and result register. Depends on fsksf_pkg and fsksf_if.
//
// Usage: software first writes the tones, symbol length, payload length,
// repeat flag and check word over the APB port, then sends load requests
// (kind 3) that fill the payload store while the framer is idle. A start
// request (kind 1) validates the setup and arms the framer; tick requests
// (kind 0) mark one millisecond each, and every symbol period one symbol is
// sent: the alternating preamble, the payload bits MSB first, then the check
// word high byte first. A stop request (kind 2) silences the tone at once.
// Every request gives exactly one result with the tone state and counters.
// A request is held in the request register from the accepting edge, and the
// framing logic fills the result register from it once that register is free
// or being drained. One request is taken every cycle while the result side
// does not stall; the framing state and the prefetched payload byte are
// updated in that same single pass.
// When the result receiver stalls, the result register holds and the
// request register fills; ready drops only when both are occupied.
// Reset is synchronous and clears the channels, the framing state and the
// registers to their defaults; the payload store is not cleared and must be
// loaded before a frame is started.
module fsk_symbol_framer_core #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  fsksf_in_if.sink                      req,
  fsksf_out_if.source                   res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsksf_pkg::PADDR_W-1:0] paddr,
  input  logic [fsksf_pkg::PDATA_W-1:0] pwdata,
  output logic [fsksf_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import fsksf_pkg::*;

  // Store address width, and a compare width wide enough for both the
  // 9-bit byte position and the store depth itself.
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned CW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(PAYLOAD_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase.
  // ---------------------------------------------------------------------
  logic [FREQ_W-1:0] zero_tone_freq;
  logic [FREQ_W-1:0] one_tone_freq;
  logic [15:0]       symbol_ticks;
  logic [LEN_W-1:0]  payload_length;
  logic              repeat_enable;
  logic [15:0]       check_value;
  logic              cfg_write;
  reg_idx_t          cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tone_freq <= '0;
      one_tone_freq  <= '0;
      symbol_ticks   <= SYMBOL_TICKS_RESET;
      payload_length <= '0;
      repeat_enable  <= 1'b0;
      check_value    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZERO_TONE:   zero_tone_freq <= pwdata[FREQ_W-1:0];
        REG_ONE_TONE:    one_tone_freq  <= pwdata[FREQ_W-1:0];
        REG_SYMBOL_TICK: symbol_ticks   <= pwdata[15:0];
        REG_PAYLOAD_LEN: payload_length <= pwdata[LEN_W-1:0];
        REG_REPEAT:      repeat_enable  <= pwdata[0];
        REG_CHECK:       check_value    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_ZERO_TONE:   prdata = PDATA_W'(zero_tone_freq);
      REG_ONE_TONE:    prdata = PDATA_W'(one_tone_freq);
      REG_SYMBOL_TICK: prdata = PDATA_W'(symbol_ticks);
      REG_PAYLOAD_LEN: prdata = PDATA_W'(payload_length);
      REG_REPEAT:      prdata = PDATA_W'(repeat_enable);
      REG_CHECK:       prdata = PDATA_W'(check_value);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request register and result register handshake. The framing pass runs
  // whenever a request is held and the result register is free or being
  // drained this cycle.
  // ---------------------------------------------------------------------
  logic              q_valid;
  kind_t             q_kind;
  logic [IDX_W-1:0]  q_load_index;
  logic [BYTE_W-1:0] q_load_byte;
  logic              out_valid;
  logic              advance;

  assign advance   = q_valid && (!out_valid || res.ready);
  assign req.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      q_kind       <= req.kind;
      q_load_index <= req.load_index;
      q_load_byte  <= req.load_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Framing state.
  // ---------------------------------------------------------------------
  logic               active, active_next;
  logic               in_preamble, in_preamble_next;
  logic [7:0]         preamble_count, preamble_count_next;
  logic [LEN_W-1:0]   byte_position, byte_position_next;
  logic [2:0]         bit_position, bit_position_next;
  logic [15:0]        tick_count, tick_count_next;
  logic [COUNT_W-1:0] symbol_count, symbol_count_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [FREQ_W-1:0]  current_freq, current_freq_next;

  // Payload store with a registered read that always holds the byte at the
  // current byte position, so a symbol can use it in the same pass.
  logic [BYTE_W-1:0]  payload_store [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0]  rd_data;
  logic               rd_in_range;
  logic [CW-1:0]      rd_pos;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      wr_pos;
  logic [AW-1:0]      wr_addr;
  logic               st_we;
  logic [BYTE_W-1:0]  stored_byte;

  assign rd_pos      = CW'(byte_position_next);
  assign rd_addr     = rd_pos[AW-1:0];
  assign wr_pos      = CW'(q_load_index);
  assign wr_addr     = wr_pos[AW-1:0];
  assign stored_byte = rd_in_range ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (st_we) begin
      payload_store[wr_addr] <= q_load_byte;
    end
    if (st_we && (wr_addr == rd_addr)) begin
      rd_data <= q_load_byte;
    end else begin
      rd_data <= payload_store[rd_addr];
    end
    rd_in_range <= rd_pos < DEPTH_C;
  end

  // Single pass over one request.
  logic [15:0]       tick_inc;
  logic [LEN_W:0]    frame_end_pos;
  logic              end_of_frame;
  logic              start_bad;
  logic              changed;
  logic              rejected;
  logic [2:0]        bit_pos_inc;
  logic [BYTE_W-1:0] check_byte;
  logic              sym_bit;

  assign tick_inc      = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign frame_end_pos = {1'b0, payload_length} + (LEN_W + 1)'(2);
  assign end_of_frame  = !in_preamble && ({1'b0, byte_position} >= frame_end_pos);
  assign start_bad     = (payload_length == '0) || (CW'(payload_length) > DEPTH_C) ||
                         (zero_tone_freq == '0) || (one_tone_freq == '0);
  assign bit_pos_inc   = bit_position + 3'd1;
  assign check_byte    = (byte_position == payload_length) ? check_value[15:8]
                                                           : check_value[7:0];

  always_comb begin
    active_next         = active;
    in_preamble_next    = in_preamble;
    preamble_count_next = preamble_count;
    byte_position_next  = byte_position;
    bit_position_next   = bit_position;
    tick_count_next     = tick_count;
    symbol_count_next   = symbol_count;
    byte_count_next     = byte_count;
    current_freq_next   = current_freq;
    changed             = 1'b0;
    rejected            = 1'b0;
    st_we               = 1'b0;
    sym_bit             = 1'b0;

    if (advance) begin
      unique case (q_kind)
        KIND_TICK: begin
          if (active) begin
            if (tick_inc >= symbol_ticks) begin
              tick_count_next = '0;
              changed         = 1'b1;
              if (end_of_frame && !repeat_enable) begin
                active_next       = 1'b0;
                current_freq_next = '0;
              end else begin
                // A repeat restart falls straight into the first preamble
                // symbol, which is the one-tone.
                if (in_preamble || end_of_frame) begin
                  sym_bit             = end_of_frame ? 1'b1 : !preamble_count[0];
                  preamble_count_next = end_of_frame ? 8'd1 : preamble_count + 8'd1;
                  in_preamble_next    = !(preamble_count_next >= PREAMBLE_SYMBOLS);
                  if (end_of_frame) begin
                    byte_position_next = '0;
                    bit_position_next  = '0;
                  end
                end else begin
                  if (byte_position < payload_length) begin
                    sym_bit = stored_byte[3'd7 - bit_position];
                    if (bit_pos_inc == 3'd0) begin
                      byte_count_next = byte_count + COUNT_W'(1);
                    end
                  end else begin
                    sym_bit = check_byte[3'd7 - bit_position];
                  end
                  bit_position_next = bit_pos_inc;
                  if (bit_pos_inc == 3'd0) begin
                    byte_position_next = byte_position + LEN_W'(1);
                  end
                  symbol_count_next = symbol_count + COUNT_W'(1);
                end
                current_freq_next = sym_bit ? one_tone_freq : zero_tone_freq;
              end
            end else begin
              tick_count_next = tick_inc;
            end
          end
        end
        KIND_START: begin
          // A running frame is silenced before the new start is checked.
          if (active) begin
            active_next       = 1'b0;
            current_freq_next = '0;
            changed           = 1'b1;
          end
          if (start_bad) begin
            rejected = 1'b1;
          end else begin
            active_next         = 1'b1;
            symbol_count_next   = '0;
            byte_count_next     = '0;
            bit_position_next   = '0;
            byte_position_next  = '0;
            in_preamble_next    = 1'b1;
            preamble_count_next = '0;
            tick_count_next     = '0;
          end
        end
        KIND_STOP: begin
          active_next       = 1'b0;
          current_freq_next = '0;
          changed           = 1'b1;
        end
        KIND_LOAD: begin
          st_we = !active && (wr_pos < DEPTH_C);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      in_preamble    <= 1'b1;
      preamble_count <= '0;
      byte_position  <= '0;
      bit_position   <= '0;
      tick_count     <= '0;
      symbol_count   <= '0;
      byte_count     <= '0;
      current_freq   <= '0;
    end else begin
      active         <= active_next;
      in_preamble    <= in_preamble_next;
      preamble_count <= preamble_count_next;
      byte_position  <= byte_position_next;
      bit_position   <= bit_position_next;
      tick_count     <= tick_count_next;
      symbol_count   <= symbol_count_next;
      byte_count     <= byte_count_next;
      current_freq   <= current_freq_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  logic               r_tone_on;
  logic [FREQ_W-1:0]  r_tone_freq;
  logic               r_tone_changed;
  logic               r_busy;
  logic               r_rejected;
  logic [COUNT_W-1:0] r_symbols;
  logic [COUNT_W-1:0] r_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_tone_on      <= current_freq_next != '0;
      r_tone_freq    <= current_freq_next;
      r_tone_changed <= changed;
      r_busy         <= active_next;
      r_rejected     <= rejected;
      r_symbols      <= symbol_count_next;
      r_bytes        <= byte_count_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.tone_on        = r_tone_on;
  assign res.tone_freq      = r_tone_freq;
  assign res.tone_changed   = r_tone_changed;
  assign res.busy_res       = r_busy;
  assign res.start_rejected = r_rejected;
  assign res.symbol_total   = r_symbols;
  assign res.byte_total     = r_bytes;

endmodule

>>> sim/fsk_symbol_framer_core_tb.sv
// Self-checking testbench for fsk_symbol_framer_core: directed and random requests
// are checked result by result against a cycle-free model of the framer.
// Depends on fsksf_pkg, fsksf_if and the RTL of fsk_symbol_framer_core.
module fsk_symbol_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsksf_pkg::*;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int CYCLE_LIMIT   = 300000;

  // One expected result: the tone state and the counters after a request.
  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        tone_changed;
    logic        busy;
    logic        rejected;
    logic [31:0] symbols;
    logic [31:0] bytes_done;
  } tone_status_t;

  // A request waiting to be offered to the block.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] index;
    logic [7:0] value;
  } framer_req_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  fsksf_in_if  req_if ();
  fsksf_out_if res_if ();

  fsk_symbol_framer_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Requests still to be offered, and the results the model expects, oldest first.
  framer_req_t  request_queue[$];
  tone_status_t expected_status[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;   // no idling on either side once set
  bit  hold_req    = 1'b0;   // asks the result side for one long stall
  int  gap_left    = 0;
  int  hold_left   = 0;

  // Register copies, updated when an APB write completes.
  logic [15:0] cfg_zero, cfg_one, cfg_ticks, cfg_check;
  logic [8:0]  cfg_len;
  logic        cfg_repeat;

  // Framer model state.
  logic [7:0]  store [PAYLOAD_DEPTH];
  logic        framer_on, in_preamble;
  logic [7:0]  pre_count;
  logic [8:0]  byte_pos;
  logic [2:0]  bit_pos;
  logic [15:0] tick_cnt, cur_freq;
  logic [31:0] sym_cnt, byte_cnt;

  // Stimulus bookkeeping: which store entries are surely written, and whether
  // the framer may be running when the next request reaches it.
  bit loaded [PAYLOAD_DEPTH];
  bit maybe_active = 1'b0;
  int gen_count    = 0;

  function automatic bit config_startable();
    return cfg_len != 0 && cfg_len <= PAYLOAD_DEPTH && cfg_zero != 0 && cfg_one != 0;
  endfunction

  function automatic void reset_framer_model();
    cfg_zero = '0; cfg_one = '0; cfg_ticks = SYMBOL_TICKS_RESET; cfg_len = '0;
    cfg_repeat = 1'b0; cfg_check = '0;
    framer_on = 1'b0; in_preamble = 1'b1; pre_count = '0; byte_pos = '0; bit_pos = '0;
    tick_cnt = '0; cur_freq = '0; sym_cnt = '0; byte_cnt = '0;
  endfunction

  // One symbol period has ended: pick the next bit of the frame and its tone.
  function automatic void send_next_symbol();
    logic       one_bit;
    logic       in_payload;
    logic [7:0] src;
    if (!in_preamble && int'(byte_pos) >= int'(cfg_len) + 2) begin
      if (!cfg_repeat) begin
        framer_on = 1'b0;
        cur_freq  = '0;
        return;
      end
      // Repeat: the frame restarts and this very symbol is the first preamble one.
      byte_pos = '0; bit_pos = '0; in_preamble = 1'b1; pre_count = '0;
    end
    if (in_preamble) begin
      one_bit   = ~pre_count[0];
      pre_count = pre_count + 8'd1;
      if (pre_count >= PREAMBLE_SYMBOLS) in_preamble = 1'b0;
    end else begin
      in_payload = byte_pos < cfg_len;
      if (in_payload) src = (byte_pos < PAYLOAD_DEPTH) ? store[byte_pos[7:0]] : 8'h00;
      else if (byte_pos == cfg_len) src = cfg_check[15:8];
      else src = cfg_check[7:0];
      one_bit = src[3'd7 - bit_pos];
      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
        byte_pos = byte_pos + 9'd1;
        if (in_payload) byte_cnt = byte_cnt + 32'd1;
      end
      sym_cnt = sym_cnt + 32'd1;
    end
    cur_freq = one_bit ? cfg_one : cfg_zero;
  endfunction

  // Advances the model by one accepted request and queues the result it gives.
  function automatic void predict_framer_step(kind_t k, logic [7:0] idx, logic [7:0] val);
    tone_status_t st;
    logic         changed;
    logic         rejected;
    changed  = 1'b0;
    rejected = 1'b0;
    case (k)
      KIND_TICK: if (framer_on) begin
        if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= cfg_ticks) begin
          tick_cnt = '0;
          send_next_symbol();
          changed = 1'b1;
        end
      end
      KIND_START: begin
        if (framer_on) begin
          framer_on = 1'b0;
          cur_freq  = '0;
          changed   = 1'b1;
        end
        if (!config_startable()) begin
          rejected = 1'b1;
        end else begin
          framer_on = 1'b1; sym_cnt = '0; byte_cnt = '0; bit_pos = '0; byte_pos = '0;
          in_preamble = 1'b1; pre_count = '0; tick_cnt = '0;
        end
      end
      KIND_STOP: begin
        framer_on = 1'b0;
        cur_freq  = '0;
        changed   = 1'b1;
      end
      default: if (!framer_on) store[idx] = val;
    endcase
    st.tone_on      = cur_freq != 0;
    st.tone_freq    = cur_freq;
    st.tone_changed = changed;
    st.busy         = framer_on;
    st.rejected     = rejected;
    st.symbols      = sym_cnt;
    st.bytes_done   = byte_cnt;
    expected_status.push_back(st);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Request driver. The request on the bus is handed to the model at the edge
  // that accepts it; values read here are still the ones being driven, since
  // every drive after the initial values in this bench is nonblocking.
  always @(posedge clk) begin
    framer_req_t nxt;
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        predict_framer_step(req_if.kind, req_if.load_index, req_if.load_byte);
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          // An idle burst before the next request.
          gap_left = $urandom_range(0, 2);
          req_if.valid <= 1'b0;
        end else begin
          nxt = request_queue.pop_front();
          req_if.valid      <= 1'b1;
          req_if.kind       <= nxt.kind;
          req_if.load_index <= nxt.index;
          req_if.load_byte  <= nxt.value;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest expectation
  // and stalls the block at random, once for a long stretch on request.
  always @(posedge clk) begin
    tone_status_t st;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          st = expected_status.pop_front();
          compare_field("tone_on", 32'(st.tone_on), 32'(res_if.tone_on));
          compare_field("tone_freq", 32'(st.tone_freq), 32'(res_if.tone_freq));
          compare_field("tone_changed", 32'(st.tone_changed), 32'(res_if.tone_changed));
          compare_field("busy_res", 32'(st.busy), 32'(res_if.busy_res));
          compare_field("start_rejected", 32'(st.rejected), 32'(res_if.start_rejected));
          compare_field("symbol_total", st.symbols, res_if.symbol_total);
          compare_field("byte_total", st.bytes_done, res_if.byte_total);
        end
      end
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fsk_symbol_framer_core_tb NOT OK");
      $finish;
    end
  end

  // Queues one request and keeps track of what the framer can be doing when it
  // arrives. A load only counts as written when the framer is surely idle, since
  // loads into a running framer are dropped.
  function automatic void add_item(kind_t k, logic [7:0] idx, logic [7:0] val);
    framer_req_t it;
    it.kind  = k;
    it.index = idx;
    it.value = val;
    request_queue.push_back(it);
    gen_count++;
    case (k)
      KIND_STOP:  maybe_active = 1'b0;
      KIND_START: maybe_active = config_startable();
      KIND_LOAD:  if (!maybe_active) loaded[idx] = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void add_random(kind_t k);
    add_item(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_ticks(int n);
    repeat (n) add_random(KIND_TICK);
  endfunction

  // A start with the store filled first, so that the frame never reads an entry
  // that was never written. Missing entries are loaded after a stop if needed.
  function automatic void add_start();
    if (config_startable()) begin
      for (int i = 0; i < int'(cfg_len); i++) begin
        if (!loaded[i]) begin
          if (maybe_active) add_random(KIND_STOP);
          add_item(KIND_LOAD, 8'(i), 8'($urandom_range(0, 255)));
        end
      end
    end
    add_random(KIND_START);
  endfunction

  // Number of ticks for one round: mostly the whole frame (or more with repeat),
  // sometimes only part of it.
  function automatic int plan_ticks();
    int per;
    int full;
    if (!config_startable()) return $urandom_range(2, 10);
    if (cfg_ticks > 16) return $urandom_range(5, 30);
    per  = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
    full = (24 + 8 * int'(cfg_len)) * per;
    if (cfg_repeat) full = full + full / 2 + $urandom_range(0, full);
    else full = full + $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) full = $urandom_range(1, full);
    return (full > 250) ? 250 : full;
  endfunction

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ZERO_TONE:   cfg_zero   = val[15:0];
      REG_ONE_TONE:    cfg_one    = val[15:0];
      REG_SYMBOL_TICK: cfg_ticks  = val[15:0];
      REG_PAYLOAD_LEN: cfg_len    = val[8:0];
      REG_REPEAT:      cfg_repeat = val[0];
      REG_CHECK:       cfg_check  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] zero_f, logic [15:0] one_f, logic [15:0] ticks,
                            logic [8:0] len, logic rep, logic [15:0] chk);
    apb_write(REG_ZERO_TONE, 32'(zero_f));
    apb_write(REG_ONE_TONE, 32'(one_f));
    apb_write(REG_SYMBOL_TICK, 32'(ticks));
    apb_write(REG_PAYLOAD_LEN, 32'(len));
    apb_write(REG_REPEAT, 32'(rep));
    apb_write(REG_CHECK, 32'(chk));
  endtask

  // Waits until every request went in and every result came out, then lets the
  // request and result registers settle a little longer.
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || req_if.valid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int          phase_no;
    int          r;
    int          n;
    logic [15:0] zf, of, tk, ck;
    logic [8:0]  ln;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.kind = KIND_TICK;
    req_if.load_index = '0; req_if.load_byte = '0;
    res_if.ready = 1'b0;
    reset_framer_model();
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset registers: the start fails on length and tones, a tick
    // while idle does nothing, a stop while idle still silences.
    add_random(KIND_START);
    add_random(KIND_TICK);
    add_random(KIND_STOP);
    add_item(KIND_LOAD, 8'hFF, 8'hFF);
    add_item(KIND_LOAD, 8'h00, 8'h00);
    wait_drained();
    // Each validation check on its own: zero tone, one tone, oversized length.
    set_config(16'h0000, 16'hFFFF, 16'd1, 9'd1, 1'b0, 16'hFFFF);
    add_random(KIND_START);
    wait_drained();
    set_config(16'hFFFF, 16'h0000, 16'd1, 9'd1, 1'b0, 16'hFFFF);
    add_random(KIND_START);
    wait_drained();
    set_config(16'd1, 16'hFFFF, 16'd1, 9'd300, 1'b0, 16'h0000);
    add_random(KIND_START);
    wait_drained();
    // A running frame: a load is dropped, a second start silences and restarts.
    set_config(16'd1, 16'hFFFF, 16'd1, 9'd1, 1'b0, 16'hFFFF);
    add_start();
    add_ticks(3);
    add_item(KIND_LOAD, 8'h05, 8'hA5);
    add_start();
    add_ticks(2);
    wait_drained();
    // The zero tone cleared mid-frame: its symbols come out silent.
    apb_write(REG_ZERO_TONE, 32'd0);
    add_ticks(2);
    add_random(KIND_STOP);
    wait_drained();

    // A longer payload at one symbol per tick, sent through to the end of the
    // frame so that the framer stops on its own.
    set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 16'd0,
               9'd40, 1'b0, 16'($urandom_range(0, 65535)));
    add_start();
    add_ticks(8 + 40 * 8 + 16 + 2);
    add_random(KIND_STOP);
    wait_drained();

    // Random phases: a fresh setting each, mostly whole frames with some noise.
    // The last phases run without idling on either side.
    phase_no = 0;
    while (!calm || gen_count < 1500) begin
      if (gen_count >= 1300) calm = 1'b1;
      zf = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      of = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      r  = $urandom_range(0, 9);
      if (r < 6) tk = 16'($urandom_range(0, 3));
      else if (r < 9) tk = 16'($urandom_range(4, 12));
      else tk = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(17, 65534));
      r = $urandom_range(0, 9);
      if (r < 7) ln = 9'($urandom_range(1, 4));
      else if (r == 7) ln = 9'($urandom_range(5, 16));
      else if (r == 8) ln = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
      else ln = 9'($urandom_range(1, 2));
      ck = 16'($urandom_range(0, 65535));
      set_config(zf, of, tk, ln, 1'($urandom_range(0, 1)), ck);

      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3)) add_random(KIND_LOAD);
        add_start();
        n = plan_ticks();
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 39);
          if (r == 0) add_random(KIND_STOP);
          else if (r == 1) add_start();
          else if (r == 2) add_random(KIND_LOAD);
          else add_random(KIND_TICK);
        end
      end
      add_random(KIND_STOP);
      // One long stall of the result side while the requests keep coming.
      if (phase_no == 1) hold_req = 1'b1;
      phase_no++;
      wait_drained();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("fsk_symbol_framer_core_tb OK");
    end else begin
      $display("fsk_symbol_framer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fsksf_pkg.sv
rtl/core/fsksf_if.sv
rtl/core/fsk_symbol_framer_core.sv
sim/fsk_symbol_framer_core_tb.sv
